@@ rtl/mesh_bounding_extents_macros.svh @@
// ----------------------------------------------------------------------------
// Mesh bounding extents: assertion macros
// Shorthand for the concurrent checks of the block, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MESH_BOUNDING_EXTENTS_MACROS_SVH
`define MESH_BOUNDING_EXTENTS_MACROS_SVH

// Same-cycle implication.
`define MBE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mesh_bounding_extents: check failed");

// Next-cycle implication.
`define MBE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mesh_bounding_extents: check failed");

`endif

@@ rtl/mbe_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh bounding extents: package
// Sequencer state type shared by the block.
// ----------------------------------------------------------------------------
package mbe_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_SUM,
    ST_RAD,
    ST_DIA,
    ST_OUT
  } mbe_state_e;

endpackage

@@ rtl/mbe_sqrt.sv @@
// ----------------------------------------------------------------------------
// Mesh bounding extents: integer square root
// Restoring floor square root, one result bit per cycle, with a one-cycle
// done pulse after the last step.
// ----------------------------------------------------------------------------
module mbe_sqrt #(
  parameter int W = 34
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [W-1:0]     value_i,
  output logic             done_o,
  output logic [W/2-1:0]   root_o
);

  logic [W-1:0] rem_q;
  logic [W-1:0] root_q;
  logic [W-1:0] bit_q;
  logic         run_q;
  logic         done_q;
  logic [W:0]   trial;
  logic         fits;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign fits  = {1'b0, rem_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && bit_q[0];
      if (start_i) begin
        run_q <= 1'b1;
      end else if (run_q && bit_q[0]) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= value_i;
      root_q <= '0;
      bit_q  <= W'(1) << (W - 2);
    end else if (run_q) begin
      if (fits) begin
        rem_q  <= rem_q - trial[W-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[W/2-1:0];

endmodule

@@ rtl/mesh_bounding_extents.sv @@
// ----------------------------------------------------------------------------
// Mesh bounding extents: top level
// Axis-aligned bounding box, bounding radius, diagonal and box centre (the
// centroid outputs) of a mesh streamed one vertex per transfer.
// ----------------------------------------------------------------------------
// A vertex is taken when start is high and busy is low. A vertex that does not
// end the mesh keeps the block busy while the squares of x, y and z pass one by
// one through the single multiplier and accumulator, so no new vertex is taken
// until that vertex is done. The final vertex also squares the box extents for
// the diagonal and takes two square roots on the one shared root unit, followed
// by eight results, one corner each, in corner order. A transfer with no_vertex
// set yields a single empty-mesh result in the next cycle. Results appear for
// one cycle with result_strobe_o and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`include "mesh_bounding_extents_macros.svh"

module mesh_bounding_extents #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic signed [COORD_BITS-1:0] z_i,
  input  logic                         last_i,
  input  logic                         no_vertex_i,
  output logic                         result_strobe_o,
  output logic signed [COORD_BITS-1:0] corner_x_o,
  output logic signed [COORD_BITS-1:0] corner_y_o,
  output logic signed [COORD_BITS-1:0] corner_z_o,
  output logic [2:0]                   corner_index_o,
  output logic [COORD_BITS-1:0]        radius_o,
  output logic [COORD_BITS:0]          diagonal_o,
  output logic signed [COORD_BITS-1:0] centroid_x_o,
  output logic signed [COORD_BITS-1:0] centroid_y_o,
  output logic signed [COORD_BITS-1:0] centroid_z_o,
  output logic                         empty_mesh_o,
  output logic                         last_result_o
);

  localparam int N      = COORD_BITS;
  localparam int LEN_W  = 2 * N;
  localparam int SQ_W   = (2 * N + 2 > 64) ? 64 : 2 * N + 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int DIAG_W = N + 1;

  localparam logic signed [N-1:0] POS_MAX = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N-1:0] NEG_MIN = {1'b1, {(N-1){1'b0}}};

  mbe_pkg::mbe_state_e state_q, state_d;

  logic                accept;
  logic [1:0]          axis_q;
  logic                diag_phase_q;
  logic [2:0]          corner_q;
  logic                strobe_q;

  logic signed [N-1:0] x_q, y_q, z_q;
  logic                last_q;
  logic signed [N-1:0] min_x_q, min_y_q, min_z_q;
  logic signed [N-1:0] max_x_q, max_y_q, max_z_q;
  logic [LEN_W-1:0]    maxlen_q;

  logic signed [N:0]   op;
  logic signed [N:0]   dx, dy, dz;
  logic signed [2*N+1:0] prod_full;
  logic [LEN_W-1:0]    prod_q;
  logic [SQ_W-1:0]     acc_q;
  logic [SQ_W:0]       sum_full;
  logic [SQ_W-1:0]     sum_sat;

  logic                sq_start;
  logic [SQ_W-1:0]     sq_value;
  logic                sq_done;
  logic [ROOT_W-1:0]   sq_root;

  logic [N-1:0]        radius_q;
  logic [DIAG_W-1:0]   diag_q;
  logic signed [N:0]   sum_cx, sum_cy, sum_cz;

  logic signed [N-1:0] cx_q, cy_q, cz_q;
  logic signed [N-1:0] mx_q, my_q, mz_q;
  logic [2:0]          cidx_q;
  logic [N-1:0]        orad_q;
  logic [DIAG_W-1:0]   odiag_q;
  logic                empty_q;
  logic                olast_q;

  assign busy   = (state_q != mbe_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mbe_pkg::ST_IDLE: begin
        if (accept && !no_vertex_i) begin
          state_d = mbe_pkg::ST_SQR;
        end
      end
      mbe_pkg::ST_SQR: begin
        if (axis_q == 2'd2) begin
          state_d = mbe_pkg::ST_SUM;
        end
      end
      mbe_pkg::ST_SUM: begin
        if (diag_phase_q) begin
          state_d = mbe_pkg::ST_RAD;
        end else if (last_q) begin
          state_d = mbe_pkg::ST_SQR;
        end else begin
          state_d = mbe_pkg::ST_IDLE;
        end
      end
      mbe_pkg::ST_RAD: begin
        if (sq_done) begin
          state_d = mbe_pkg::ST_DIA;
        end
      end
      mbe_pkg::ST_DIA: begin
        if (sq_done) begin
          state_d = mbe_pkg::ST_OUT;
        end
      end
      mbe_pkg::ST_OUT: begin
        if (&corner_q) begin
          state_d = mbe_pkg::ST_IDLE;
        end
      end
      default: state_d = mbe_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs to the root unit.
  always_comb begin
    sq_start = 1'b0;
    sq_value = SQ_W'(maxlen_q);
    case (state_q)
      mbe_pkg::ST_SUM: sq_start = diag_phase_q;
      mbe_pkg::ST_RAD: begin
        sq_start = sq_done;
        sq_value = acc_q;
      end
      default: sq_start = 1'b0;
    endcase
  end

  assign dx = {max_x_q[N-1], max_x_q} - {min_x_q[N-1], min_x_q};
  assign dy = {max_y_q[N-1], max_y_q} - {min_y_q[N-1], min_y_q};
  assign dz = {max_z_q[N-1], max_z_q} - {min_z_q[N-1], min_z_q};

  always_comb begin
    case (axis_q)
      2'd0:    op = diag_phase_q ? dx : {x_q[N-1], x_q};
      2'd1:    op = diag_phase_q ? dy : {y_q[N-1], y_q};
      2'd2:    op = diag_phase_q ? dz : {z_q[N-1], z_q};
      default: op = '0;
    endcase
  end

  assign prod_full = op * op;
  assign sum_full  = {1'b0, acc_q} + (SQ_W+1)'(prod_q);
  assign sum_sat   = sum_full[SQ_W] ? '1 : sum_full[SQ_W-1:0];

  assign sum_cx = {min_x_q[N-1], min_x_q} + {max_x_q[N-1], max_x_q};
  assign sum_cy = {min_y_q[N-1], min_y_q} + {max_y_q[N-1], max_y_q};
  assign sum_cz = {min_z_q[N-1], min_z_q} + {max_z_q[N-1], max_z_q};

  mbe_sqrt #(
    .W (SQ_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_value),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mbe_pkg::ST_IDLE;
      axis_q       <= '0;
      diag_phase_q <= 1'b0;
      corner_q     <= '0;
      strobe_q     <= 1'b0;
      min_x_q      <= POS_MAX;
      min_y_q      <= POS_MAX;
      min_z_q      <= POS_MAX;
      max_x_q      <= NEG_MIN;
      max_y_q      <= NEG_MIN;
      max_z_q      <= NEG_MIN;
      maxlen_q     <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (accept && no_vertex_i) || (state_q == mbe_pkg::ST_OUT);
      if (accept) begin
        axis_q       <= '0;
        diag_phase_q <= 1'b0;
        if (no_vertex_i) begin
          min_x_q  <= POS_MAX;
          min_y_q  <= POS_MAX;
          min_z_q  <= POS_MAX;
          max_x_q  <= NEG_MIN;
          max_y_q  <= NEG_MIN;
          max_z_q  <= NEG_MIN;
          maxlen_q <= '0;
        end else begin
          if (x_i < min_x_q) min_x_q <= x_i;
          if (y_i < min_y_q) min_y_q <= y_i;
          if (z_i < min_z_q) min_z_q <= z_i;
          if (x_i > max_x_q) max_x_q <= x_i;
          if (y_i > max_y_q) max_y_q <= y_i;
          if (z_i > max_z_q) max_z_q <= z_i;
        end
      end
      if (state_q == mbe_pkg::ST_SQR) begin
        axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
      end
      if (state_q == mbe_pkg::ST_SUM && !diag_phase_q) begin
        if (sum_sat[LEN_W-1:0] > maxlen_q) begin
          maxlen_q <= sum_sat[LEN_W-1:0];
        end
        if (last_q) begin
          diag_phase_q <= 1'b1;
        end
      end
      if (state_q == mbe_pkg::ST_DIA && sq_done) begin
        corner_q <= '0;
      end
      if (state_q == mbe_pkg::ST_OUT) begin
        corner_q <= corner_q + 3'd1;
        if (&corner_q) begin
          min_x_q  <= POS_MAX;
          min_y_q  <= POS_MAX;
          min_z_q  <= POS_MAX;
          max_x_q  <= NEG_MIN;
          max_y_q  <= NEG_MIN;
          max_z_q  <= NEG_MIN;
          maxlen_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      last_q <= last_i;
    end
    if (state_q == mbe_pkg::ST_SQR) begin
      prod_q <= prod_full[LEN_W-1:0];
      acc_q  <= (axis_q == 2'd0) ? '0 : sum_sat;
    end
    if (state_q == mbe_pkg::ST_SUM) begin
      acc_q <= sum_sat;
    end
    if (state_q == mbe_pkg::ST_RAD && sq_done) begin
      radius_q <= N'(sq_root);
    end
    if (state_q == mbe_pkg::ST_DIA && sq_done) begin
      diag_q <= DIAG_W'(sq_root);
    end
    if (accept && no_vertex_i) begin
      mx_q    <= '0;
      my_q    <= '0;
      mz_q    <= '0;
      cidx_q  <= '0;
      orad_q  <= '0;
      odiag_q <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      empty_q <= 1'b1;
      olast_q <= 1'b1;
    end else if (state_q == mbe_pkg::ST_OUT) begin
      mx_q    <= corner_q[0] ? max_x_q : min_x_q;
      my_q    <= corner_q[1] ? max_y_q : min_y_q;
      mz_q    <= corner_q[2] ? max_z_q : min_z_q;
      cidx_q  <= corner_q;
      orad_q  <= radius_q;
      odiag_q <= diag_q;
      cx_q    <= sum_cx[N:1];
      cy_q    <= sum_cy[N:1];
      cz_q    <= sum_cz[N:1];
      empty_q <= 1'b0;
      olast_q <= &corner_q;
    end
  end

  assign result_strobe_o = strobe_q;
  assign corner_x_o      = mx_q;
  assign corner_y_o      = my_q;
  assign corner_z_o      = mz_q;
  assign corner_index_o  = cidx_q;
  assign radius_o        = orad_q;
  assign diagonal_o      = odiag_q;
  assign centroid_x_o    = cx_q;
  assign centroid_y_o    = cy_q;
  assign centroid_z_o    = cz_q;
  assign empty_mesh_o    = empty_q;
  assign last_result_o   = olast_q;

  `MBE_ASSERT_IMP(a_mid_corner_busy, result_strobe_o && !last_result_o, busy)
  `MBE_ASSERT_IMP(a_root_done_waited,
                  sq_done, state_q == mbe_pkg::ST_RAD || state_q == mbe_pkg::ST_DIA)
  `MBE_ASSERT_NXT(a_vertex_makes_busy, start && !busy && !no_vertex_i, busy)
  `MBE_ASSERT_NXT(a_corner_sequence, result_strobe_o && !last_result_o,
                  result_strobe_o && corner_index_o == 3'($past(corner_index_o) + 3'd1))

endmodule
